@@ rtl/core/s2a_pkg.sv @@
// Shared types, constants and the translation tables of the scancode unit.
`timescale 1ns / 1ps

package s2a_pkg;

   localparam int TABLE_ROWS = 58;

   typedef enum logic [1:0] {
      OP_SCAN  = 2'd0,
      OP_POP   = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_CAPS         = 8'h3A;
   localparam logic [7:0] SC_UP           = 8'h48;
   localparam logic [7:0] SC_DOWN         = 8'h50;
   localparam logic [7:0] SC_LEFT         = 8'h4B;
   localparam logic [7:0] SC_RIGHT        = 8'h4D;
   localparam logic [7:0] SC_QUOTE_ROW    = 8'h27;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [2:0] REG_LAYOUT = 3'd0;
   localparam logic [2:0] REG_UP     = 3'd1;
   localparam logic [2:0] REG_DOWN   = 3'd2;
   localparam logic [2:0] REG_LEFT   = 3'd3;
   localparam logic [2:0] REG_RIGHT  = 3'd4;

   // Each row holds the shifted character in the upper byte and the plain one below.
   localparam logic [15:0] XLAT_EN [TABLE_ROWS] = '{
      16'h0000, 16'h1B1B, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
      16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
      16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
      16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'h0000, 16'h4161, 16'h5373,
      16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
      16'h2227, 16'h7E60, 16'h0000, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
      16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'h0000, 16'h0000,
      16'h0000, 16'h2020
   };

   localparam logic [15:0] XLAT_ES [TABLE_ROWS] = '{
      16'h0000, 16'h1B1B, 16'h2131, 16'h2232, 16'h2333, 16'h2434, 16'h2535, 16'h2636,
      16'h2F37, 16'h2838, 16'h2939, 16'h3D30, 16'h3F27, 16'h7D7C, 16'h0808, 16'h0909,
      16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
      16'h4F6F, 16'h5070, 16'h2260, 16'h2A2B, 16'h0A0A, 16'h0000, 16'h4161, 16'h5373,
      16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h7E7F,
      16'h5B7B, 16'h7E60, 16'h0000, 16'h5D7D, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
      16'h4262, 16'h4E6E, 16'h4D6D, 16'h3B2C, 16'h3A2E, 16'h5F2D, 16'h0000, 16'h0000,
      16'h0000, 16'h2020
   };

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] data;
   } fifo_cmd_type;

   function automatic logic [15:0] xlat_row(input logic layout, input logic [5:0] idx);
      logic [15:0] row;
      row = 16'h0000;
      if (int'(idx) < TABLE_ROWS) begin
         row = layout ? XLAT_ES[idx] : XLAT_EN[idx];
      end
      return row;
   endfunction

endpackage

@@ rtl/core/s2a_char_fifo.sv @@
// Ring buffer of characters with a prefetched oldest word and a newest-word register.
`timescale 1ns / 1ps

module s2a_char_fifo #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  s2a_pkg::fifo_cmd_type        cmd,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic [7:0]                   head_char,
   output logic [7:0]                   last_char
);
   import s2a_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    newest_ff, newest_in;
   logic [7:0]    rd_ff;
   logic          byp_ff;
   logic [7:0]    byp_data_ff;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      logic [AW-1:0] q;
      q = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
      return q;
   endfunction

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      newest_in = newest_ff;
      if (cmd.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd.push) begin
         tail_in   = ptr_inc(tail_ff);
         count_in  = count_ff + 1'b1;
         newest_in = cmd.data;
      end else if (cmd.pop) begin
         head_in  = ptr_inc(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         byp_ff   <= cmd.push && !cmd.clear && (tail_ff == head_in);
      end
      newest_ff   <= newest_in;
      byp_data_ff <= cmd.data;
   end

   // The oldest word is read every cycle at the next head address; a write to
   // that same address in the same cycle is forwarded instead.
   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         mem[tail_ff] <= cmd.data;
      end
      rd_ff <= mem[head_in];
   end

   assign count     = count_ff;
   assign head_char = byp_ff ? byp_data_ff : rd_ff;
   assign last_char = (count_ff != '0) ? newest_ff : 8'h00;

endmodule

@@ rtl/core/scancode_to_ascii_fifo_unit.sv @@
// Top level of the set-1 scancode translator with its character buffer.
`timescale 1ns / 1ps

// A command word (req_opcode, req_scancode) is taken at each rising edge at
// which start is high; busy is always low, so a word may be given every cycle.
// Opcode scan translates a scancode, updates the shift and caps flags or
// stores an arrow code; pop removes the oldest character; clear empties the
// buffer. Every command word gives exactly one result word, shown for one
// cycle with rsp_valid high from the rising edge after the one that took the
// command. The command passes an input register, is worked combinationally
// against the buffer state, and its result is registered, so throughput is
// one word per cycle. The oldest character is prefetched from the buffer
// memory every cycle, which lets pops follow each other without a gap.
// The receiver cannot stall the result channel; a result not taken is lost.
// Reset empties the buffer, clears shift and caps, and restores the layout and
// arrow code registers; buffer contents themselves are not cleared.
// Registers sit on the APB-style port at byte addresses 0, 4, 8, 12 and 16.
module scancode_to_ascii_fifo_unit #(
   parameter int FIFO_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_scancode,
   output logic        rsp_valid,
   output logic [7:0]  rsp_key_out,
   output logic        rsp_key_valid,
   output logic [7:0]  rsp_last_char,
   output logic [6:0]  rsp_fill_count,
   output logic        rsp_dropped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import s2a_pkg::*;

   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic          layout_ff;
   logic [7:0]    up_ff, down_ff, left_ff, right_ff;
   logic [2:0]    reg_idx;
   logic          reg_write;

   logic          in_valid_ff;
   opcode_type    op_ff;
   logic [7:0]    sc_ff;

   logic          shift_ff, shift_in;
   logic          caps_ff, caps_in;
   logic          push_req;
   logic [7:0]    push_data;
   logic [15:0]   row_word;
   logic          letter;
   logic          full;
   fifo_cmd_type  cmd;

   logic [CW-1:0] count;
   logic [CW+6:0] count_ext;
   logic [7:0]    head_char;
   logic [7:0]    last_char;

   logic          rsp_valid_ff;
   logic [7:0]    key_ff;
   logic          key_valid_ff;
   logic          dropped_ff;

   assign busy    = 1'b0;
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign reg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= 1'b1;
         up_ff     <= 8'd128;
         down_ff   <= 8'd129;
         left_ff   <= 8'd130;
         right_ff  <= 8'd131;
      end else if (reg_write) begin
         case (reg_idx)
            REG_LAYOUT: layout_ff <= pwdata[0];
            REG_UP:     up_ff     <= pwdata[7:0];
            REG_DOWN:   down_ff   <= pwdata[7:0];
            REG_LEFT:   left_ff   <= pwdata[7:0];
            REG_RIGHT:  right_ff  <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LAYOUT: prdata = {31'd0, layout_ff};
         REG_UP:     prdata = {24'd0, up_ff};
         REG_DOWN:   prdata = {24'd0, down_ff};
         REG_LEFT:   prdata = {24'd0, left_ff};
         REG_RIGHT:  prdata = {24'd0, right_ff};
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      op_ff <= opcode_type'(req_opcode);
      sc_ff <= req_scancode;
   end

   assign full     = (count == CW'(FIFO_DEPTH));
   assign row_word = xlat_row(layout_ff, sc_ff[5:0]);
   assign letter   = (sc_ff == SC_QUOTE_ROW) ||
                     ((row_word[7:0] >= CHAR_LOWER_A) && (row_word[7:0] <= CHAR_LOWER_Z));

   always_comb begin
      shift_in  = shift_ff;
      caps_in   = caps_ff;
      push_req  = 1'b0;
      push_data = 8'h00;
      if (in_valid_ff && (op_ff == OP_SCAN)) begin
         case (sc_ff)
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_in = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_in = 1'b0;
            SC_CAPS:                          caps_in  = !caps_ff;
            SC_UP: begin
               push_req  = 1'b1;
               push_data = up_ff;
            end
            SC_DOWN: begin
               push_req  = 1'b1;
               push_data = down_ff;
            end
            SC_LEFT: begin
               push_req  = 1'b1;
               push_data = left_ff;
            end
            SC_RIGHT: begin
               push_req  = 1'b1;
               push_data = right_ff;
            end
            default: begin
               if ((sc_ff != 8'h00) && (sc_ff < 8'(TABLE_ROWS))) begin
                  push_req  = 1'b1;
                  push_data = ((letter && caps_ff) || shift_ff) ? row_word[15:8]
                                                                : row_word[7:0];
               end
            end
         endcase
      end
   end

   always_comb begin
      cmd.push  = push_req && !full;
      cmd.pop   = in_valid_ff && (op_ff == OP_POP) && (count != '0);
      cmd.clear = in_valid_ff && (op_ff == OP_CLEAR);
      cmd.data  = push_data;
   end

   s2a_char_fifo #(
      .DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .count     (count),
      .head_char (head_char),
      .last_char (last_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         caps_ff      <= caps_in;
         rsp_valid_ff <= in_valid_ff;
      end
      key_ff       <= cmd.pop ? head_char : 8'h00;
      key_valid_ff <= cmd.pop;
      dropped_ff   <= push_req && full;
   end

   // Buffer state seen here is the state left by the word being reported.
   assign count_ext      = {7'd0, count};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_out    = key_ff;
   assign rsp_key_valid  = key_valid_ff;
   assign rsp_dropped    = dropped_ff;
   assign rsp_last_char  = last_char;
   assign rsp_fill_count = count_ext[6:0];

endmodule

@@ verif/scancode_to_ascii_fifo_unit_tb.sv @@
// Self-checking testbench of the scancode translator and its character buffer.
`timescale 1ns / 1ps

module scancode_to_ascii_fifo_unit_tb;
   import s2a_pkg::*;

   localparam int BUFFER_DEPTH = 64;
   localparam int BUFFER_AW = $clog2(BUFFER_DEPTH);
   localparam int DIRECTED_ROWS = 26;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] key_out;
      logic       key_valid;
      logic [7:0] last_char;
      logic [6:0] fill_count;
      logic       dropped;
   } key_status_type;

   typedef struct packed {
      logic [1:0]     opcode;
      logic [7:0]     scancode;
      logic           typed;
      key_status_type want;
   } directed_row_type;

   localparam key_status_type EMPTY_STATUS = '0;

   // Plain and shifted columns of both layouts, indexed by scancode.
   localparam logic [7:0] EN_PLAIN [TABLE_ROWS] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
      8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
   };
   localparam logic [7:0] EN_SHIFTED [TABLE_ROWS] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
      8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
   };
   localparam logic [7:0] ES_PLAIN [TABLE_ROWS] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h27, 8'h7C, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
      8'h6A, 8'h6B, 8'h6C, 8'h7F, 8'h7B, 8'h60, 8'h00, 8'h7D, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h20
   };
   localparam logic [7:0] ES_SHIFTED [TABLE_ROWS] = '{
      8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28, 8'h29, 8'h3D,
      8'h3F, 8'h7D, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h22, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
      8'h4A, 8'h4B, 8'h4C, 8'h7E, 8'h5B, 8'h7E, 8'h00, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h20
   };

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_POP,    8'h00,           1'b1, EMPTY_STATUS},
      '{OP_SCAN,   8'h00,           1'b1, EMPTY_STATUS},
      '{OP_SCAN,   8'hFF,           1'b1, EMPTY_STATUS},
      '{OP_UNUSED, 8'h1E,           1'b1, EMPTY_STATUS},
      '{OP_SCAN,   8'h1E,           1'b1, '{8'h00, 1'b0, 8'h61, 7'd1, 1'b0}},
      '{OP_SCAN,   SC_LSHIFT_MAKE,  1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h02,           1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_LSHIFT_BREAK, 1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_RSHIFT_MAKE,  1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h0C,           1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_RSHIFT_BREAK, 1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_CAPS,         1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h10,           1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_QUOTE_ROW,    1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h03,           1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_CAPS,         1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_UP,           1'b1, '{8'h00, 1'b0, 8'h80, 7'd7, 1'b0}},
      '{OP_SCAN,   SC_DOWN,         1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_LEFT,         1'b0, EMPTY_STATUS},
      '{OP_SCAN,   SC_RIGHT,        1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h1D,           1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h39,           1'b0, EMPTY_STATUS},
      '{OP_SCAN,   8'h3B,           1'b0, EMPTY_STATUS},
      '{OP_POP,    8'h00,           1'b0, EMPTY_STATUS},
      '{OP_CLEAR,  8'h00,           1'b1, EMPTY_STATUS},
      '{OP_POP,    8'h00,           1'b1, EMPTY_STATUS}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_SCAN;
   logic [7:0]  req_scancode = 8'h00;
   logic        rsp_valid;
   logic [7:0]  rsp_key_out;
   logic        rsp_key_valid;
   logic [7:0]  rsp_last_char;
   logic [6:0]  rsp_fill_count;
   logic        rsp_dropped;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [7:0]  kb_buffer [BUFFER_DEPTH];
   int          kb_count = 0;
   int          kb_head = 0;
   logic        shift_held = 1'b0;
   logic        caps_on = 1'b0;
   logic        cfg_layout = 1'b1;
   logic [7:0]  cfg_up = 8'd128;
   logic [7:0]  cfg_down = 8'd129;
   logic [7:0]  cfg_left = 8'd130;
   logic [7:0]  cfg_right = 8'd131;

   key_status_type key_status_due [$];
   int             error_count = 0;
   bit             allow_gaps = 1'b1;

   scancode_to_ascii_fifo_unit #(
      .FIFO_DEPTH(BUFFER_DEPTH)
   ) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_scancode(req_scancode),
      .rsp_valid(rsp_valid), .rsp_key_out(rsp_key_out), .rsp_key_valid(rsp_key_valid),
      .rsp_last_char(rsp_last_char), .rsp_fill_count(rsp_fill_count),
      .rsp_dropped(rsp_dropped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic void store_char(input logic [7:0] ch, inout key_status_type status);
      if (kb_count >= BUFFER_DEPTH) begin
         status.dropped = 1'b1;
      end else begin
         kb_buffer[BUFFER_AW'((kb_head + kb_count) % BUFFER_DEPTH)] = ch;
         kb_count++;
      end
   endfunction

   function automatic key_status_type update_keyboard(input logic [1:0] opcode,
                                                      input logic [7:0] scancode);
      key_status_type status;
      logic [7:0]     plain;
      logic [7:0]     shifted;
      logic           letter;
      status = '0;
      if (opcode == OP_SCAN) begin
         case (scancode)
            SC_LSHIFT_MAKE, SC_RSHIFT_MAKE: shift_held = 1'b1;
            SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_held = 1'b0;
            SC_CAPS: caps_on = ~caps_on;
            SC_UP: store_char(cfg_up, status);
            SC_DOWN: store_char(cfg_down, status);
            SC_LEFT: store_char(cfg_left, status);
            SC_RIGHT: store_char(cfg_right, status);
            default: begin
               if (scancode != 8'h00 && int'(scancode) < TABLE_ROWS) begin
                  plain = cfg_layout ? ES_PLAIN[scancode[5:0]] : EN_PLAIN[scancode[5:0]];
                  shifted = cfg_layout ? ES_SHIFTED[scancode[5:0]]
                                       : EN_SHIFTED[scancode[5:0]];
                  letter = (scancode == SC_QUOTE_ROW) ||
                           (plain >= CHAR_LOWER_A && plain <= CHAR_LOWER_Z);
                  store_char((letter && caps_on) || shift_held ? shifted : plain, status);
               end
            end
         endcase
      end else if (opcode == OP_POP) begin
         if (kb_count > 0) begin
            status.key_out = kb_buffer[BUFFER_AW'(kb_head)];
            status.key_valid = 1'b1;
            kb_head = (kb_head + 1) % BUFFER_DEPTH;
            kb_count--;
         end
      end else if (opcode == OP_CLEAR) begin
         kb_count = 0;
         kb_head = 0;
      end
      if (kb_count > 0) begin
         status.last_char = kb_buffer[BUFFER_AW'((kb_head + kb_count - 1) % BUFFER_DEPTH)];
      end
      status.fill_count = 7'(kb_count);
      return status;
   endfunction

   function automatic logic [1:0] pick_opcode(input int pop_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < pop_pct) return OP_POP;
      if (roll < pop_pct + 1) return OP_CLEAR;
      if (roll < pop_pct + 3) return OP_UNUSED;
      return OP_SCAN;
   endfunction

   function automatic logic [7:0] pick_scancode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 8'($urandom_range(1, TABLE_ROWS - 1));
      if (roll < 63) begin
         case ($urandom_range(0, 3))
            0: return SC_LSHIFT_MAKE;
            1: return SC_RSHIFT_MAKE;
            2: return SC_LSHIFT_BREAK;
            default: return SC_RSHIFT_BREAK;
         endcase
      end
      if (roll < 68) return SC_CAPS;
      if (roll < 80) begin
         case ($urandom_range(0, 3))
            0: return SC_UP;
            1: return SC_DOWN;
            2: return SC_LEFT;
            default: return SC_RIGHT;
         endcase
      end
      return 8'($urandom);
   endfunction

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      key_status_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (key_status_due.size() == 0) begin
            $display("%0t: result word with no command outstanding", $time);
            error_count++;
         end else begin
            want = key_status_due.pop_front();
            check_field("key_out", want.key_out, rsp_key_out);
            check_field("key_valid", 8'(want.key_valid), 8'(rsp_key_valid));
            check_field("last_char", want.last_char, rsp_last_char);
            check_field("fill_count", 8'(want.fill_count), 8'(rsp_fill_count));
            check_field("dropped", 8'(want.dropped), 8'(rsp_dropped));
         end
      end
   end

   task automatic send_word(input logic [1:0] opcode, input logic [7:0] scancode,
                            input logic typed, input key_status_type want);
      key_status_type predicted;
      while (allow_gaps && $urandom_range(0, 99) < 23) begin
         start <= 1'b0;
         req_opcode <= 2'($urandom);
         req_scancode <= 8'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= opcode;
      req_scancode <= scancode;
      do begin
         @(posedge clock);
      end while (busy);
      predicted = update_keyboard(opcode, scancode);
      key_status_due.push_back(typed ? want : predicted);
   endtask

   task automatic wait_results_drained();
      start <= 1'b0;
      while (key_status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {24'h000000, value};
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_LAYOUT: cfg_layout = value[0];
         REG_UP: cfg_up = value;
         REG_DOWN: cfg_down = value;
         REG_LEFT: cfg_left = value;
         REG_RIGHT: cfg_right = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic run_random(input int items, input int pop_pct, input bit pause_halfway);
      for (int n = 0; n < items; n++) begin
         if (pause_halfway && n == items / 2) begin
            wait_results_drained();
         end
         send_word(pick_opcode(pop_pct), pick_scancode(), 1'b0, EMPTY_STATUS);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_word(DIRECTED[i].opcode, DIRECTED[i].scancode, DIRECTED[i].typed,
                   DIRECTED[i].want);
      end
      // Overfill the buffer with letters, then empty it past the bottom.
      repeat (BUFFER_DEPTH + 3) send_word(OP_SCAN, 8'($urandom_range(16, 25)), 1'b0,
                                          EMPTY_STATUS);
      repeat (BUFFER_DEPTH + 2) send_word(OP_POP, 8'($urandom), 1'b0, EMPTY_STATUS);
      wait_results_drained();

      write_register(REG_LAYOUT, 8'h00);
      write_register(REG_UP, 8'h00);
      write_register(REG_DOWN, 8'hFF);
      write_register(REG_LEFT, 8'h55);
      write_register(REG_RIGHT, 8'hAA);
      run_random(250, 20, 1'b0);
      wait_results_drained();

      write_register(REG_LAYOUT, 8'h01);
      write_register(REG_UP, 8'hFF);
      write_register(REG_DOWN, 8'h00);
      write_register(REG_LEFT, 8'($urandom));
      write_register(REG_RIGHT, 8'($urandom));
      run_random(250, 50, 1'b1);
      wait_results_drained();

      write_register(REG_LAYOUT, 8'h00);
      write_register(REG_UP, 8'($urandom));
      write_register(REG_DOWN, 8'($urandom));
      write_register(REG_LEFT, 8'hFF);
      write_register(REG_RIGHT, 8'h00);
      allow_gaps = 1'b0;
      run_random(120, 35, 1'b0);
      allow_gaps = 1'b1;
      run_random(130, 35, 1'b0);
      wait_results_drained();

      write_register(REG_LAYOUT, 8'h01);
      write_register(REG_UP, 8'($urandom));
      write_register(REG_DOWN, 8'($urandom));
      write_register(REG_LEFT, 8'($urandom));
      write_register(REG_RIGHT, 8'($urandom));
      run_random(250, 45, 1'b0);
      wait_results_drained();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/s2a_pkg.sv
rtl/core/s2a_char_fifo.sv
rtl/core/scancode_to_ascii_fifo_unit.sv
verif/scancode_to_ascii_fifo_unit_tb.sv
